// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared sizes, entry layout, command bundle and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH   = 8;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int TAG_W   = 16;
   localparam int PRIO_W  = 2;
   localparam int OCC_W   = 4;

   localparam logic [PRIO_W-1:0] PRIO_LEAST = 2'd2;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      FN_ENQ = 1'b0,
      FN_DEQ = 1'b1
   } func_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type new_entry;
   } cmd_type;

endpackage

// ===== rtl/core/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted chain; keeps, inserts or shifts its entry.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic               valid,
   input  logic               left_stays,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic               stays
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // An entry stays put when it is at least as urgent as the new one.
   assign stays = valid && (entry_ff.prio <= cmd.new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq) begin
         if (stays) begin
            entry_in = entry_ff;
         end else if (left_stays) begin
            entry_in = cmd.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/core/stable_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue unit
// Bounded priority queue held sorted in a chain of cells, FIFO within a level.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Contents
//   --------+-----------+------------------------------------------------------
//   req_*   | in        | tuser = func; tdata = tag, priority_req
//   rsp_*   | out       | tdata = status, out_tag, out_priority, occupancy
//
// Every request is handled in the cycle it is accepted; its response appears
// in the output register on the next cycle, so one request per cycle flows
// while the receiver keeps taking responses. The rate is set by the cell
// chain, which compares and shifts every slot at once.
// A request is accepted while the response register is empty or being drained.
// Reset empties the queue at once; slot contents need no clearing.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] func
   input  logic [23:0] req_tdata,   // [15:0] tag, [17:16] priority_req, [23:18] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [1:0] status, [17:2] out_tag,
                                    // [19:18] out_priority, [23:20] occupancy
);

   localparam int N = spq_pkg::DEPTH;

   logic [spq_pkg::CNT_W-1:0] count_ff;
   logic [spq_pkg::CNT_W-1:0] count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [23:0]               rsp_data_ff;
   logic [23:0]               rsp_data_in;

   logic                     accept;
   logic                     is_full;
   logic                     is_empty;
   logic [spq_pkg::PRIO_W-1:0] req_prio;
   spq_pkg::cmd_type         cmd;
   spq_pkg::status_type      status;
   spq_pkg::entry_type       head;

   spq_pkg::entry_type cell_entry [N];
   logic [N-1:0]       cell_stays;
   logic [N-1:0]       cell_valid;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == spq_pkg::CNT_W'(N));
   assign is_empty   = (count_ff == '0);

   // A priority of three is outside the range and counts as least urgent.
   assign req_prio = (req_tdata[17:16] > spq_pkg::PRIO_LEAST) ? spq_pkg::PRIO_LEAST
                                                              : req_tdata[17:16];

   always_comb begin
      cmd.new_entry.tag  = req_tdata[15:0];
      cmd.new_entry.prio = req_prio;
      cmd.enq = accept && (req_tuser[0] == spq_pkg::FN_ENQ) && !is_full;
      cmd.deq = accept && (req_tuser[0] == spq_pkg::FN_DEQ) && !is_empty;
   end

   // The chain: cell 0 is the head; new entries enter where the prefix of
   // stay-put cells ends, and a dequeue shifts everything toward the head.
   generate
      for (genvar i = 0; i < N; i++) begin : g_cell
         assign cell_valid[i] = (spq_pkg::CNT_W'(i) < count_ff);
         spq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .valid       (cell_valid[i]),
            .left_stays  ((i == 0) ? 1'b1 : cell_stays[(i == 0) ? 0 : i - 1]),
            .left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
            .right_entry (cell_entry[(i == N - 1) ? i : i + 1]),
            .entry       (cell_entry[i]),
            .stays       (cell_stays[i])
         );
      end
   endgenerate

   assign head = cell_entry[0];

   always_comb begin
      count_in = count_ff;
      if (cmd.enq) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      status = spq_pkg::ST_DONE;
      if (req_tuser[0] == spq_pkg::FN_ENQ) begin
         if (is_full) begin
            status = spq_pkg::ST_FULL;
         end
      end else if (is_empty) begin
         status = spq_pkg::ST_EMPTY;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_data_in         = '0;
         rsp_data_in[1:0]    = status;
         if (cmd.deq) begin
            rsp_data_in[17:2]  = head.tag;
            rsp_data_in[19:18] = head.prio;
         end
         rsp_data_in[23:20]  = spq_pkg::OCC_W'(count_in);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The fill count never exceeds the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::CNT_W'(N))
      else $error("queue count exceeds depth");

   // A successful enqueue grows the queue by one.
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      cmd.enq |=> count_ff == $past(count_ff) + 1'b1)
      else $error("enqueue did not increment count");

   // A successful dequeue shrinks the queue by one.
   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      cmd.deq |=> count_ff == $past(count_ff) - 1'b1)
      else $error("dequeue did not decrement count");

   // A rejected request leaves the queue untouched.
   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      accept && status != spq_pkg::ST_DONE |=> $stable(count_ff))
      else $error("rejected request changed count");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Drives enqueue and dequeue requests into the queue unit, predicts each
// response from a shadow copy of the sorted queue and compares every field.
// ----------------------------------------------------------------------------
module tb_top;
   import spq_pkg::*;

   // Response layout as it travels on rsp_tdata, lowest field last here.
   typedef struct packed {
      logic [OCC_W-1:0]  occupancy;
      logic [PRIO_W-1:0] out_priority;
      logic [TAG_W-1:0]  out_tag;
      logic [1:0]        status;
   } rsp_fields_type;

   // The scoreboard keeps its own sorted copy of the queue. Each accepted
   // request updates that copy and leaves the response it must cause in a
   // FIFO, since the unit answers requests strictly in order.
   class queue_scoreboard;
      entry_type      shadow_slots[DEPTH];
      int             shadow_fill = 0;
      rsp_fields_type awaited_rsp[$];
      int             mismatches = 0;

      function void note_request(func_type fn, logic [TAG_W-1:0] tag,
                                 logic [PRIO_W-1:0] prio_in);
         rsp_fields_type   exp;
         logic [PRIO_W-1:0] level;
         int               slot;
         exp = '0;
         // Levels above the least urgent one are saturated to it.
         level = (prio_in > PRIO_LEAST) ? PRIO_LEAST : prio_in;
         if (fn == FN_ENQ) begin
            if (shadow_fill >= DEPTH) begin
               exp.status = ST_FULL;
            end else begin
               // Go behind every entry of equal or more urgent level.
               slot = 0;
               while (slot < shadow_fill && shadow_slots[slot].prio <= level)
                  slot++;
               for (int i = shadow_fill; i > slot; i--)
                  shadow_slots[i] = shadow_slots[i-1];
               shadow_slots[slot] = {level, tag};
               shadow_fill++;
               exp.status = ST_DONE;
            end
         end else begin
            if (shadow_fill == 0) begin
               exp.status = ST_EMPTY;
            end else begin
               exp.status       = ST_DONE;
               exp.out_tag      = shadow_slots[0].tag;
               exp.out_priority = shadow_slots[0].prio;
               for (int i = 1; i < shadow_fill; i++)
                  shadow_slots[i-1] = shadow_slots[i];
               shadow_fill--;
            end
         end
         exp.occupancy = shadow_fill[OCC_W-1:0];
         awaited_rsp.push_back(exp);
      endfunction

      function void check_response(logic [23:0] data);
         rsp_fields_type got;
         rsp_fields_type exp;
         got = data;
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response %h arrived with none outstanding", $realtime, data);
         end else begin
            exp = awaited_rsp.pop_front();
            if (got.status !== exp.status || got.out_tag !== exp.out_tag ||
                got.out_priority !== exp.out_priority ||
                got.occupancy !== exp.occupancy) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: status %0d/%0d tag %h/%h prio %0d/%0d occ %0d/%0d (exp/got)",
                           $realtime, exp.status, got.status, exp.out_tag, got.out_tag,
                           exp.out_priority, got.out_priority, exp.occupancy,
                           got.occupancy);
            end
         end
      endfunction

      function int outstanding();
         return awaited_rsp.size();
      endfunction
   endclass

   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [0:0]  req_tuser;    // [0] func
   logic [23:0] req_tdata;    // [15:0] tag, [17:16] priority_req, [23:18] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;    // [1:0] status, [17:2] out_tag,
                              // [19:18] out_priority, [23:20] occupancy

   queue_scoreboard sb = new();

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int send_idle_pct = 0;
   int stall_pct = 0;
   // The stimulus bumps this count to ask the receiver for one long hold-off.
   int hold_asked = 0;

   stable_priority_queue_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: checks every accepted response and decides tready for the
   // next cycle. A hold-off is counted here so that the sender keeps
   // offering requests while the response register stays full.
   int hold_seen = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Watchdog: a run that goes this long without moving a request or a
   // response on either side is stuck.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request, possibly after idling first, and returns in the
   // time step in which it was accepted. The sender's inputs are changed here
   // right after the clock rises, and otherwise only at reset and at the end.
   task automatic send_request(input func_type fn, input logic [TAG_W-1:0] tag,
                               input logic [PRIO_W-1:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {6'b0, prio, tag};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_request(fn, tag, prio);
   endtask

   // A burst of random requests whose mix of enqueues and dequeues is set by
   // enq_pct, so that the queue drifts between empty, half full and full.
   task automatic send_burst(input int items, input int enq_pct);
      func_type fn;
      for (int n = 0; n < items; n++) begin
         fn = ($urandom_range(99) < enq_pct) ? FN_ENQ : FN_DEQ;
         send_request(fn, TAG_W'($urandom_range(16'hFFFF)), PRIO_W'($urandom_range(3)));
      end
   endtask

   initial begin
      int phase_items;
      int bias;
      int burst_len;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= FN_ENQ;
      req_tdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: a dequeue from the empty queue, a fill up to full
      // with every level and the out-of-range level, an enqueue rejected
      // because the queue is full, then a drain past empty. The equal levels
      // in the fill show whether ties leave in arrival order.
      send_request(FN_DEQ, 16'h0000, 2'd0);
      send_request(FN_ENQ, 16'hFFFF, 2'd3);
      send_request(FN_ENQ, 16'h0000, 2'd0);
      send_request(FN_ENQ, 16'h1111, 2'd1);
      send_request(FN_ENQ, 16'h2222, 2'd2);
      send_request(FN_ENQ, 16'h3333, 2'd0);
      send_request(FN_ENQ, 16'h4444, 2'd1);
      send_request(FN_ENQ, 16'h5555, 2'd3);
      send_request(FN_ENQ, 16'hAAAA, 2'd2);
      send_request(FN_ENQ, 16'hBEEF, 2'd0);
      for (int n = 0; n < DEPTH; n++)
         send_request(FN_DEQ, (n % 2) ? 16'hFFFF : 16'h0000, (n % 2) ? 2'd3 : 2'd0);
      send_request(FN_DEQ, 16'h5A5A, 2'd1);

      // Random part in four idling phases: none, sender idle, receiver
      // stalling, and both. The first phase opens with a long receiver
      // hold-off so that the unit backs up and deasserts req_tready.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
               hold_asked++;
            end
            1: begin
               send_idle_pct = 74;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 74;
            end
            default: begin
               send_idle_pct = 15;
               stall_pct = 15;
            end
         endcase
         phase_items = 0;
         while (phase_items < 135) begin
            case ($urandom_range(3))
               0: bias = 25;
               1: bias = 50;
               2: bias = 75;
               default: bias = 90;
            endcase
            burst_len = 8 + $urandom_range(16);
            send_burst(burst_len, bias);
            phase_items += burst_len;
         end
      end
      req_tvalid <= 1'b0;

      // Drain: the watchdog bounds this wait if responses stop coming.
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue_unit.sv
dv/tb_top.sv
